/* rtl/cppcrc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cppcrc_pkg
// Types, constants and functions shared by the configuration packet parser.
// ----------------------------------------------------------------------------
package cppcrc_pkg;

    localparam int WORD_W  = 32;
    localparam int ADDR_W  = 5;
    localparam int COUNT_W = 27;
    localparam int TYPE1_COUNT_W = 11;

    localparam logic [WORD_W-1:0] SYNC_WORD = 32'hAA99_5566;
    localparam logic [WORD_W-1:0] NOOP_WORD = 32'h2000_0000;
    localparam logic [WORD_W-1:0] ZERO_WORD = 32'h0000_0000;
    localparam logic [WORD_W-1:0] CRC_POLY  = 32'h1EDC_6F41;
    localparam logic [WORD_W-1:0] CMD_RCRC  = 32'h0000_0007;
    localparam logic [WORD_W-1:0] IDCODE_RESET = 32'h0165_8093;

    localparam logic [2:0] HDR_TYPE1 = 3'd1;
    localparam logic [2:0] HDR_TYPE2 = 3'd2;

    localparam logic [ADDR_W-1:0] ADDR_CRC    = 5'd0;
    localparam logic [ADDR_W-1:0] ADDR_FAR    = 5'd1;
    localparam logic [ADDR_W-1:0] ADDR_FDRI   = 5'd2;
    localparam logic [ADDR_W-1:0] ADDR_CMD    = 5'd4;
    localparam logic [ADDR_W-1:0] ADDR_LOUT   = 5'd8;
    localparam logic [ADDR_W-1:0] ADDR_IDCODE = 5'd12;

    typedef enum logic [1:0] {
        PH_UNSYNCED = 2'd0,
        PH_HEADER   = 2'd1,
        PH_DATA     = 2'd2,
        PH_HALTED   = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        EV_SKIPPED = 3'd0,
        EV_SYNC    = 3'd1,
        EV_IGNORED = 3'd2,
        EV_HEADER  = 3'd3,
        EV_DATA    = 3'd4,
        EV_ERROR   = 3'd5,
        EV_HALTED  = 3'd6
    } t_event;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_UNKNOWN    = 2'd1,
        ERR_FRAME_LEN  = 2'd2,
        ERR_IDCODE     = 2'd3
    } t_err;

    // Frame length in words. The divisibility test below splits it into a
    // power of two and an odd factor, and tests the odd factor by multiplying
    // with its inverse modulo 2**COUNT_W.
    localparam int FRAME_WORDS = 41;

    function automatic int f_trailing_zeros(input int d);
        int n;
        int v;
        n = 0;
        v = d;
        for (int i = 0; i < 11; i++) begin
            if ((v % 2 == 0) && (v != 0)) begin
                v = v / 2;
                n = n + 1;
            end
        end
        return n;
    endfunction

    function automatic logic [COUNT_W-1:0] f_inverse(input logic [COUNT_W-1:0] d);
        logic [COUNT_W-1:0] x;
        x = d;
        for (int i = 0; i < 5; i++) begin
            x = x * (COUNT_W'(2) - d * x);
        end
        return x;
    endfunction

    localparam int FW_TZ  = f_trailing_zeros(FRAME_WORDS);
    localparam int FW_ODD = FRAME_WORDS >> FW_TZ;
    localparam logic [COUNT_W-1:0] FW_LOW_MASK = COUNT_W'((64'd1 << FW_TZ) - 64'd1);
    localparam logic [COUNT_W-1:0] FW_INV   = f_inverse(COUNT_W'(FW_ODD));
    localparam logic [COUNT_W-1:0] FW_LIMIT = COUNT_W'(((64'd1 << COUNT_W) - 64'd1) / FW_ODD);

    function automatic logic f_frame_multiple(input logic [COUNT_W-1:0] n);
        logic [COUNT_W-1:0] odd_part;
        logic [COUNT_W-1:0] prod;
        odd_part = n >> FW_TZ;
        prod     = odd_part * FW_INV;
        return ((n & FW_LOW_MASK) == '0) && (prod <= FW_LIMIT);
    endfunction

    // One CRC-32C shift step, most significant bit first.
    function automatic logic [WORD_W-1:0] f_crc_bit(input logic [WORD_W-1:0] c, input logic b);
        logic fb;
        fb = c[WORD_W-1] ^ b;
        return {c[WORD_W-2:0], 1'b0} ^ (fb ? CRC_POLY : ZERO_WORD);
    endfunction

    // Data bits least significant first, then the register address bits.
    function automatic logic [WORD_W-1:0] f_crc_word(input logic [WORD_W-1:0] crc,
                                                     input logic [ADDR_W-1:0] addr,
                                                     input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] c;
        c = crc;
        for (int i = 0; i < WORD_W; i++) begin
            c = f_crc_bit(c, w[i]);
        end
        for (int i = 0; i < ADDR_W; i++) begin
            c = f_crc_bit(c, addr[i]);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* rtl/cppcrc_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cppcrc_in_if
// Input channel: one configuration stream word per item.
// ----------------------------------------------------------------------------
interface cppcrc_in_if
    import cppcrc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word;
    logic              restart;

    modport source (output valid, output word, output restart, input ready);
    modport sink   (input valid, input word, input restart, output ready);
endinterface
`default_nettype wire

/* rtl/cppcrc_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cppcrc_out_if
// Output channel: one parser result per item.
// ----------------------------------------------------------------------------
interface cppcrc_out_if
    import cppcrc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [2:0]         event_res;
    logic [ADDR_W-1:0]  reg_addr;
    logic [WORD_W-1:0]  value;
    logic [WORD_W-1:0]  crc_value;
    logic [COUNT_W-1:0] words_left;
    logic [1:0]         error_code;

    modport source (output valid, output event_res, output reg_addr, output value,
                    output crc_value, output words_left, output error_code, input ready);
    modport sink   (input valid, input event_res, input reg_addr, input value,
                    input crc_value, input words_left, input error_code, output ready);
endinterface
`default_nettype wire

/* rtl/config_packet_processor_crc.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// config_packet_processor_crc
// Configuration packet parser with a CRC-32C check register.
// An accepted item is held in the input register, then in the result register.
// Throughput is one item per cycle unless the output stalls; the parse and the
// 37-bit CRC update sit in one stage between the input and result registers.
// Synchronous active-low reset returns to the unsynced search, clears the
// CRC and packet state and loads the default expected IDCODE.
// ----------------------------------------------------------------------------
module config_packet_processor_crc
    import cppcrc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [WORD_W-1:0] i_cfg_wr_data,
    cppcrc_in_if.sink              i_item,
    cppcrc_out_if.source           o_item
);

    logic [WORD_W-1:0]  r_idcode;

    logic               r_in_valid;
    logic [WORD_W-1:0]  r_word;
    logic               r_restart;

    t_phase             r_phase,  n_phase;
    logic [ADDR_W-1:0]  r_active, n_active;
    logic [COUNT_W-1:0] r_remain, n_remain;
    logic [WORD_W-1:0]  r_crc,    n_crc;
    logic               r_rcrc,   n_rcrc;

    logic               r_out_valid;
    t_event             r_out_event, n_event;
    t_err               r_out_err,   n_err;
    logic [ADDR_W-1:0]  r_out_addr;
    logic [WORD_W-1:0]  r_out_value;
    logic [WORD_W-1:0]  r_out_crc;
    logic [COUNT_W-1:0] r_out_remain;

    logic               advance;
    t_phase             cur_phase;
    logic [COUNT_W-1:0] cur_remain;
    logic [COUNT_W-1:0] dec_remain;

    assign advance      = r_in_valid && (!r_out_valid || o_item.ready);
    assign i_item.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idcode <= IDCODE_RESET;
        end else if (i_cfg_wr_en) begin
            r_idcode <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_word    <= i_item.word;
            r_restart <= i_item.restart;
        end
    end

    always_comb begin
        cur_phase  = r_restart ? PH_UNSYNCED : r_phase;
        cur_remain = r_restart ? '0 : r_remain;
        dec_remain = (cur_remain != '0) ? cur_remain - COUNT_W'(1) : cur_remain;
        n_phase    = cur_phase;
        n_active   = r_active;
        n_remain   = cur_remain;
        n_crc      = r_crc;
        n_rcrc     = r_rcrc;
        n_event    = EV_SKIPPED;
        n_err      = ERR_NONE;
        unique case (cur_phase)
            PH_UNSYNCED: begin
                if (r_word == SYNC_WORD) begin
                    n_phase = PH_HEADER;
                    n_event = EV_SYNC;
                end
            end
            PH_HEADER: begin
                if (r_word == NOOP_WORD || r_word == ZERO_WORD) begin
                    n_event = EV_IGNORED;
                end else if (r_word[31:29] == HDR_TYPE1 || r_word[31:29] == HDR_TYPE2) begin
                    if (r_word[31:29] == HDR_TYPE1) begin
                        n_active = r_word[17:13];
                        n_remain = COUNT_W'(r_word[TYPE1_COUNT_W-1:0]);
                    end else begin
                        n_remain = r_word[COUNT_W-1:0];
                    end
                    n_event = EV_HEADER;
                    if (n_remain != '0) begin
                        n_phase = PH_DATA;
                        if (n_active == ADDR_FDRI && !f_frame_multiple(n_remain)) begin
                            n_event = EV_ERROR;
                            n_err   = ERR_FRAME_LEN;
                            n_phase = PH_HALTED;
                        end
                    end
                end else begin
                    n_event = EV_ERROR;
                    n_err   = ERR_UNKNOWN;
                    n_phase = PH_HALTED;
                end
            end
            PH_DATA: begin
                n_event  = EV_DATA;
                n_remain = dec_remain;
                if (r_active != ADDR_LOUT) begin
                    n_crc = f_crc_word(r_crc, r_active, r_word);
                end
                if (r_active == ADDR_CMD) begin
                    n_rcrc = (r_word == CMD_RCRC);
                end
                if (dec_remain == '0) begin
                    n_phase = PH_HEADER;
                    if ((r_active == ADDR_CMD || r_active == ADDR_FAR) && n_rcrc) begin
                        n_crc = '0;
                    end
                    if (r_active == ADDR_IDCODE && r_word != r_idcode) begin
                        n_event = EV_ERROR;
                        n_err   = ERR_IDCODE;
                        n_phase = PH_HALTED;
                    end
                end
            end
            PH_HALTED: begin
                n_event = EV_HALTED;
            end
            default: begin
                n_event = EV_HALTED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_UNSYNCED;
            r_active <= '0;
            r_remain <= '0;
            r_crc    <= '0;
            r_rcrc   <= 1'b0;
        end else if (advance) begin
            r_phase  <= n_phase;
            r_active <= n_active;
            r_remain <= n_remain;
            r_crc    <= n_crc;
            r_rcrc   <= n_rcrc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_item.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_event  <= n_event;
            r_out_err    <= n_err;
            r_out_addr   <= n_active;
            r_out_value  <= r_word;
            r_out_crc    <= n_crc;
            r_out_remain <= n_remain;
        end
    end

    assign o_item.valid      = r_out_valid;
    assign o_item.event_res  = r_out_event;
    assign o_item.reg_addr   = r_out_addr;
    assign o_item.value      = r_out_value;
    assign o_item.crc_value  = r_out_crc;
    assign o_item.words_left = r_out_remain;
    assign o_item.error_code = r_out_err;

    // An error result always leaves the parser halted.
    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_event == EV_ERROR |=> r_phase == PH_HALTED)
        else $error("error item did not halt the parser");

    // A halted parser changes no CRC or packet state until restart.
    a_halt_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_phase == PH_HALTED && !r_restart
        |=> $stable(r_crc) && $stable(r_remain) && $stable(r_active))
        else $error("halted parser changed its state");

    // A held input item is not lost while the result register is full.
    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_word) && $stable(r_restart))
        else $error("pending input item was overwritten");

    // The error code is set exactly on error results.
    a_error_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out_event == EV_ERROR) == (r_out_err != ERR_NONE))
        else $error("error code does not match event");

endmodule
`default_nettype wire

/* tb/cppcrc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cppcrc_checker
// Watches the input and output channels and the IDCODE write port of the
// configuration packet parser. Each accepted item is run through a local
// parser and CRC-32C model. Each accepted result is compared field by field
// with the oldest predicted result.
// ----------------------------------------------------------------------------
module cppcrc_checker
    import cppcrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [WORD_W-1:0] i_cfg_wr_data,
    cppcrc_in_if              i_in_ch,
    cppcrc_out_if             i_out_ch,
    output int                o_mismatches,
    output int                o_pending,
    output int                o_checked,
    output int                o_error_events
);

    typedef struct packed {
        t_event             ev;
        logic [ADDR_W-1:0]  addr;
        logic [WORD_W-1:0]  value;
        logic [WORD_W-1:0]  crc;
        logic [COUNT_W-1:0] left;
        t_err               err;
    } t_parse_result;

    t_phase             phase;
    logic [ADDR_W-1:0]  active_reg;
    logic [COUNT_W-1:0] remaining;
    logic [WORD_W-1:0]  crc_reg;
    logic               cmd_rcrc;
    logic [WORD_W-1:0]  idcode;
    t_parse_result      parse_results_q[$];
    t_parse_result      want;

    initial begin
        o_mismatches   = 0;
        o_pending      = 0;
        o_checked      = 0;
        o_error_events = 0;
    end

    function automatic logic [WORD_W-1:0] crc32c_advance(input logic [WORD_W-1:0] crc,
                                                         input logic [ADDR_W-1:0] addr,
                                                         input logic [WORD_W-1:0] w);
        logic [WORD_W+ADDR_W-1:0] bits;
        logic [WORD_W-1:0]        c;
        bits = {addr, w};
        c    = crc;
        for (int i = 0; i < WORD_W + ADDR_W; i++) begin
            if (c[WORD_W-1] ^ bits[i]) begin
                c = {c[WORD_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[WORD_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic t_parse_result parse_config_word(input logic [WORD_W-1:0] w,
                                                        input logic restart);
        t_parse_result r;
        logic [2:0]    htype;
        r.ev  = EV_SKIPPED;
        r.err = ERR_NONE;
        htype = w[31:29];
        if (restart) begin
            phase     = PH_UNSYNCED;
            remaining = '0;
        end
        case (phase)
            PH_UNSYNCED: begin
                if (w == SYNC_WORD) begin
                    phase = PH_HEADER;
                    r.ev  = EV_SYNC;
                end
            end
            PH_HEADER: begin
                if (w == NOOP_WORD || w == ZERO_WORD) begin
                    r.ev = EV_IGNORED;
                end else if (htype != HDR_TYPE1 && htype != HDR_TYPE2) begin
                    r.ev  = EV_ERROR;
                    r.err = ERR_UNKNOWN;
                    phase = PH_HALTED;
                end else begin
                    if (htype == HDR_TYPE1) begin
                        active_reg = w[17:13];
                        remaining  = COUNT_W'(w[10:0]);
                    end else begin
                        remaining = w[COUNT_W-1:0];
                    end
                    r.ev = EV_HEADER;
                    if (remaining != '0) begin
                        phase = PH_DATA;
                        if (active_reg == ADDR_FDRI && (remaining % FRAME_WORDS) != 0) begin
                            r.ev  = EV_ERROR;
                            r.err = ERR_FRAME_LEN;
                            phase = PH_HALTED;
                        end
                    end
                end
            end
            PH_DATA: begin
                r.ev = EV_DATA;
                if (active_reg != ADDR_LOUT) begin
                    crc_reg = crc32c_advance(crc_reg, active_reg, w);
                end
                if (active_reg == ADDR_CMD) begin
                    cmd_rcrc = (w == CMD_RCRC);
                end
                if (remaining != '0) begin
                    remaining = remaining - 1'b1;
                end
                if (remaining == '0) begin
                    phase = PH_HEADER;
                    if ((active_reg == ADDR_CMD || active_reg == ADDR_FAR) && cmd_rcrc) begin
                        crc_reg = '0;
                    end
                    if (active_reg == ADDR_IDCODE && w != idcode) begin
                        r.ev  = EV_ERROR;
                        r.err = ERR_IDCODE;
                        phase = PH_HALTED;
                    end
                end
            end
            default: r.ev = EV_HALTED;
        endcase
        r.addr  = active_reg;
        r.value = w;
        r.crc   = crc_reg;
        r.left  = remaining;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want_v);
        if (o_mismatches < 40) begin
            $display("[%0t] MISMATCH result %0d, %s: got %0h, expected %0h",
                     $time, o_checked, field, got, want_v);
        end
        o_mismatches = o_mismatches + 1;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase      = PH_UNSYNCED;
            active_reg = '0;
            remaining  = '0;
            crc_reg    = '0;
            cmd_rcrc   = 1'b0;
            idcode     = IDCODE_RESET;
            parse_results_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                idcode = i_cfg_wr_data;
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                parse_results_q.push_back(parse_config_word(i_in_ch.word, i_in_ch.restart));
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (parse_results_q.size() == 0) begin
                    report_mismatch("unexpected item", {29'd0, i_out_ch.event_res}, '0);
                end else begin
                    want = parse_results_q.pop_front();
                    if (i_out_ch.event_res != want.ev) begin
                        report_mismatch("event_res", 32'(i_out_ch.event_res), 32'(want.ev));
                    end
                    if (i_out_ch.reg_addr != want.addr) begin
                        report_mismatch("reg_addr", 32'(i_out_ch.reg_addr), 32'(want.addr));
                    end
                    if (i_out_ch.value != want.value) begin
                        report_mismatch("value", i_out_ch.value, want.value);
                    end
                    if (i_out_ch.crc_value != want.crc) begin
                        report_mismatch("crc_value", i_out_ch.crc_value, want.crc);
                    end
                    if (i_out_ch.words_left != want.left) begin
                        report_mismatch("words_left", 32'(i_out_ch.words_left), 32'(want.left));
                    end
                    if (i_out_ch.error_code != want.err) begin
                        report_mismatch("error_code", 32'(i_out_ch.error_code), 32'(want.err));
                    end
                    if (want.ev == EV_ERROR) begin
                        o_error_events = o_error_events + 1;
                    end
                    o_checked = o_checked + 1;
                end
            end
        end
        o_pending = parse_results_q.size();
    end

endmodule

/* tb/tb_config_packet_processor_crc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_config_packet_processor_crc
// Drives the configuration packet parser with a short directed stream and
// then with random bursts of well-formed packets mixed with noise, under
// several flow-control phases and expected IDCODE settings. The checker
// module predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_config_packet_processor_crc;
    import cppcrc_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_wr_en;
    logic [WORD_W-1:0] cfg_wr_data;

    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                words_sent     = 0;
    int                phase_start;
    logic [WORD_W-1:0] idcode_now     = IDCODE_RESET;
    logic [ADDR_W-1:0] last_addr      = ADDR_CRC;

    int mismatches;
    int pending;
    int checked;
    int error_events;

    cppcrc_in_if  in_ch();
    cppcrc_out_if out_ch();

    config_packet_processor_crc i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_item        (in_ch),
        .o_item        (out_ch)
    );

    cppcrc_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_ch        (in_ch),
        .i_out_ch       (out_ch),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_error_events (error_events)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results still expected", pending);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [WORD_W-1:0] type1_header(input logic [ADDR_W-1:0] addr,
                                                       input logic [10:0] count);
        return {HDR_TYPE1, 11'd0, addr, 2'd0, count};
    endfunction

    task automatic send_word(input logic [WORD_W-1:0] w, input logic restart);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.word    = w;
        in_ch.restart = restart;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        words_sent = words_sent + 1;
    endtask

    task automatic wait_until_idle();
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_idcode(input logic [WORD_W-1:0] v);
        wait_until_idle();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge i_clk);
        cfg_wr_en   = 1'b0;
        idcode_now  = v;
    endtask

    task automatic send_directed_stream();
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(SYNC_WORD, 1'b0);
        send_word(NOOP_WORD, 1'b0);
        send_word(ZERO_WORD, 1'b0);
        send_word(type1_header(ADDR_CRC, 11'd2), 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h1234_5678, 1'b0);
        send_word(type1_header(ADDR_CMD, 11'd1), 1'b0);
        send_word(CMD_RCRC, 1'b0);
        send_word(type1_header(ADDR_FAR, 11'd1), 1'b0);
        send_word(ZERO_WORD, 1'b0);
        send_word(type1_header(ADDR_LOUT, 11'd1), 1'b0);
        send_word(32'hDEAD_BEEF, 1'b0);
        send_word(type1_header(ADDR_IDCODE, 11'd1), 1'b0);
        send_word(IDCODE_RESET, 1'b0);
        send_word(type1_header(ADDR_FDRI, 11'd0), 1'b0);
        send_word({HDR_TYPE2, 2'b00, COUNT_W'(FRAME_WORDS)}, 1'b0);
        send_word(32'h5A5A_A5A5, 1'b0);
        send_word(SYNC_WORD, 1'b1);
        // A type 2 count of all ones is not a whole number of frames.
        send_word({HDR_TYPE2, 2'b00, {COUNT_W{1'b1}}}, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(SYNC_WORD, 1'b1);
        send_word(SYNC_WORD, 1'b0);
        send_word(SYNC_WORD, 1'b1);
        send_word(type1_header(ADDR_IDCODE, 11'd1), 1'b0);
        send_word(ZERO_WORD, 1'b0);
        last_addr = ADDR_IDCODE;
    endtask

    task automatic send_random_packet();
        int                roll;
        int                n_data;
        logic [2:0]        htype;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] w;
        roll = $urandom_range(99);
        if (roll < 8) begin
            send_word(($urandom_range(1) == 0) ? NOOP_WORD : ZERO_WORD, 1'b0);
        end else if (roll < 11) begin
            htype = 3'($urandom_range(2, 7));
            if (htype == HDR_TYPE2) htype = 3'd0;
            send_word({htype, 29'($urandom)}, 1'b0);
        end else begin
            if (roll < 30) begin
                addr = last_addr;
            end else begin
                case ($urandom_range(7))
                    0: addr = ADDR_CRC;
                    1: addr = ADDR_FAR;
                    2: addr = ADDR_FDRI;
                    3, 4: addr = ADDR_CMD;
                    5: addr = ADDR_LOUT;
                    6: addr = ADDR_IDCODE;
                    default: addr = ADDR_W'($urandom);
                endcase
                last_addr = addr;
            end
            if (addr == ADDR_FDRI) begin
                n_data = ($urandom_range(4) == 0) ? $urandom_range(1, 60) : FRAME_WORDS;
            end else begin
                n_data = $urandom_range(0, 4);
            end
            if (roll < 30) begin
                w = {HDR_TYPE2, 2'b00, COUNT_W'(n_data)};
            end else begin
                w = {HDR_TYPE1, 11'($urandom), addr, 2'($urandom), 11'(n_data)};
            end
            send_word(w, 1'b0);
            for (int i = 0; i < n_data; i++) begin
                if (addr == ADDR_CMD && $urandom_range(1) == 0) begin
                    w = CMD_RCRC;
                end else if (addr == ADDR_IDCODE && $urandom_range(7) != 0) begin
                    w = idcode_now;
                end else begin
                    w = $urandom;
                end
                send_word(w, 1'b0);
            end
        end
    endtask

    task automatic send_random_burst();
        int n_packets;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 4)) send_word($urandom, ($urandom_range(3) == 0));
        end else begin
            send_word(SYNC_WORD, ($urandom_range(7) != 0));
            n_packets = $urandom_range(1, 6);
            repeat (n_packets) send_random_packet();
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        in_ch.valid   = 1'b0;
        in_ch.word    = '0;
        in_ch.restart = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    send_directed_stream();
                end
                1: begin
                    write_idcode(32'h0000_0000);
                    send_idle_pct  = 55;
                    recv_stall_pct = 0;
                end
                2: begin
                    write_idcode(32'hFFFF_FFFF);
                    send_idle_pct  = 0;
                    recv_stall_pct = 55;
                end
                3: begin
                    write_idcode($urandom);
                    send_idle_pct  = 34;
                    recv_stall_pct = 34;
                end
                default: begin
                    write_idcode(IDCODE_RESET);
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            phase_start = words_sent;
            while (words_sent - phase_start < 180) send_random_burst();
        end
        wait_until_idle();

        $display("Checked %0d results from %0d words over five flow-control phases",
                 checked, words_sent);
        $display("and four expected IDCODE settings; %0d of the results were errors.",
                 error_events);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
